FILE: rtl/signed_integer_to_radix_text_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for signed_integer_to_radix_text
// Shared immediate-consequence and next-cycle property forms on i_clk.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SIRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sirt assertion failed");

// next-cycle implication, disabled in reset
`define SIRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sirt assertion failed");

`endif

FILE: rtl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Types, constants and the reciprocal table of the radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W     = $clog2(MAX_DIGITS);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd2;

    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_LZ    = 8'h7A;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_UZ    = 8'h5A;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_FIX,
        ST_SIGN,
        ST_DIGITS,
        ST_BAD
    } t_state;

    typedef struct packed {
        logic load;
        logic chk_step;
        logic mul;
        logic fix;
        logic emit_sign;
        logic emit_digit;
        logic emit_bad;
    } t_dp_cmd;

    typedef struct packed {
        logic size_bad;
        logic chk_bad;
        logic chk_done;
        logic q_zero;
        logic neg;
        logic last_digit;
        logic out_free;
    } t_dp_sts;

    // floor(2^32 / radix)
    function automatic logic [31:0] recip_of(input logic [4:0] radix);
        logic [31:0] m;
        unique case (radix)
            5'd2:    m = 32'h8000_0000;
            5'd3:    m = 32'h5555_5555;
            5'd4:    m = 32'h4000_0000;
            5'd5:    m = 32'h3333_3333;
            5'd6:    m = 32'h2AAA_AAAA;
            5'd7:    m = 32'h2492_4924;
            5'd8:    m = 32'h2000_0000;
            5'd9:    m = 32'h1C71_C71C;
            5'd10:   m = 32'h1999_9999;
            5'd11:   m = 32'h1745_D174;
            5'd12:   m = 32'h1555_5555;
            5'd13:   m = 32'h13B1_3B13;
            5'd14:   m = 32'h1249_2492;
            5'd15:   m = 32'h1111_1111;
            5'd16:   m = 32'h1000_0000;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Writes a signed 32-bit value as text in the radix of a configured alphabet.
//
//   channel  direction  handshake               payload
//   cfg      in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//   in       in         i_in_valid/o_in_ready   i_value
//   out      out        o_out_valid/i_out_ready o_symbol, o_last_symbol,
//                                               o_bad_alphabet
//
// One item at a time: accept, one alphabet check step per symbol (up to
// 16), a reciprocal multiply step and a correct step per digit (up to 32
// digits), then the characters one by one (up to 33). The longest item is
// radix 2 with the most negative value.
// A bad alphabet ends the check early and gives one flagged result.
// Reset is synchronous; it clears the alphabet, the sequencer and the output valid flag.
// An output stall holds the current character and pauses emission.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [31:0]               i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_symbol,
    output logic                             o_last_symbol,
    output logic                             o_bad_alphabet
);
    import sirt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    sirt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sirt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_symbol       (o_symbol),
        .o_last_symbol  (o_last_symbol),
        .o_bad_alphabet (o_bad_alphabet)
    );

endmodule

FILE: rtl/sirt_datapath.sv
// ----------------------------------------------------------------------------
// sirt_datapath
// Alphabet registers, alphabet check, reciprocal divider, digit stack and
// output register.
// ----------------------------------------------------------------------------
module sirt_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    input  logic signed [31:0]               i_value,
    input  sirt_pkg::t_dp_cmd                i_cmd,
    output sirt_pkg::t_dp_sts                o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [7:0]                       o_symbol,
    output logic                             o_last_symbol,
    output logic                             o_bad_alphabet
);
    import sirt_pkg::*;

    logic [4:0]        r_size;
    logic [63:0]       r_low;
    logic [63:0]       r_high;
    logic [31:0]       r_mag,   n_mag;
    logic [31:0]       r_recip, n_recip;
    logic [31:0]       r_q0,    n_q0;
    logic              r_neg,   n_neg;
    logic [NDIG_W-1:0] r_ndig,  n_ndig;
    logic [3:0]        r_vidx,  n_vidx;
    logic [3:0]        r_digits [MAX_DIGITS];
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_symbol, n_symbol;
    logic              r_last,   n_last;
    logic              r_bad,    n_bad;

    logic [7:0]        cur_sym;
    logic              dup;
    logic [63:0]       prod;
    logic [31:0]       size32;
    logic [31:0]       fix_rem0;
    logic              fix_corr;
    logic [31:0]       fix_q;
    logic [31:0]       fix_rem;
    logic [DIDX_W-1:0] rd_idx;
    logic [3:0]        rd_digit;
    logic              out_free;

    function automatic logic [7:0] sym_at(input logic [3:0] k, input logic [63:0] lo,
                                          input logic [63:0] hi);
        logic [5:0] base;
        base = {k[2:0], 3'b000};
        return k[3] ? hi[base +: 8] : lo[base +: 8];
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_LA && c <= CHR_LZ) ||
               (c >= CHR_UA && c <= CHR_UZ);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE: r_size <= i_cfg_data[4:0];
                CFG_LOW:  r_low  <= i_cfg_data;
                CFG_HIGH: r_high <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb begin
        cur_sym = sym_at(r_vidx, r_low, r_high);
        dup     = 1'b0;
        for (int j = 0; j < 16; j++) begin
            if (5'(j) < r_size && 4'(j) > r_vidx && sym_at(4'(j), r_low, r_high) == cur_sym) begin
                dup = 1'b1;
            end
        end
    end

    assign prod     = {32'd0, r_mag} * {32'd0, r_recip};
    assign size32   = {27'd0, r_size};
    assign fix_rem0 = r_mag - r_q0 * size32;
    assign fix_corr = fix_rem0 >= size32;
    assign fix_q    = r_q0 + {31'd0, fix_corr};
    assign fix_rem  = fix_corr ? fix_rem0 - size32 : fix_rem0;
    assign rd_idx   = DIDX_W'(r_ndig - NDIG_W'(1));
    assign rd_digit = r_digits[rd_idx];
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.size_bad   = r_size < 5'd2 || r_size > 5'(MAX_RADIX);
        o_sts.chk_bad    = !is_alnum(cur_sym) || dup;
        o_sts.chk_done   = r_vidx == 4'(r_size - 5'd1);
        o_sts.q_zero     = fix_q == 32'd0;
        o_sts.neg        = r_neg;
        o_sts.last_digit = r_ndig == NDIG_W'(1);
        o_sts.out_free   = out_free;
    end

    always_comb begin
        n_mag   = r_mag;
        n_recip = r_recip;
        n_q0    = r_q0;
        n_neg   = r_neg;
        n_ndig  = r_ndig;
        n_vidx  = r_vidx;
        if (i_cmd.load) begin
            n_neg   = i_value[31];
            n_mag   = i_value[31] ? 32'd0 - $unsigned(i_value) : $unsigned(i_value);
            n_recip = recip_of(r_size);
            n_ndig  = '0;
            n_vidx  = '0;
        end
        if (i_cmd.chk_step) begin
            n_vidx = r_vidx + 4'd1;
        end
        if (i_cmd.mul) begin
            n_q0 = prod[63:32];
        end
        if (i_cmd.fix) begin
            n_mag  = fix_q;
            n_ndig = r_ndig + NDIG_W'(1);
        end
        if (i_cmd.emit_digit) begin
            n_ndig = r_ndig - NDIG_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_symbol    = r_symbol;
        n_last      = r_last;
        n_bad       = r_bad;
        if (i_cmd.emit_sign) begin
            n_out_valid = 1'b1;
            n_symbol    = CHR_MINUS;
            n_last      = 1'b0;
            n_bad       = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_out_valid = 1'b1;
            n_symbol    = sym_at(rd_digit, r_low, r_high);
            n_last      = r_ndig == NDIG_W'(1);
            n_bad       = 1'b0;
        end
        if (i_cmd.emit_bad) begin
            n_out_valid = 1'b1;
            n_symbol    = 8'd0;
            n_last      = 1'b1;
            n_bad       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_recip  <= n_recip;
        r_q0     <= n_q0;
        r_neg    <= n_neg;
        r_ndig   <= n_ndig;
        r_vidx   <= n_vidx;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_bad    <= n_bad;
        if (i_cmd.fix) begin
            r_digits[r_ndig[DIDX_W-1:0]] <= fix_rem[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_symbol;
    assign o_last_symbol  = r_last;
    assign o_bad_alphabet = r_bad;

endmodule

FILE: rtl/sirt_ctrl.sv
// ----------------------------------------------------------------------------
// sirt_ctrl
// Sequencer: accept, alphabet check, divide loop, character emission.
// ----------------------------------------------------------------------------
module sirt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sirt_pkg::t_dp_sts  i_sts,
    output sirt_pkg::t_dp_cmd  o_cmd
);
    import sirt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (i_sts.size_bad || i_sts.chk_bad) n_state = ST_BAD;
                else if (i_sts.chk_done)                    n_state = ST_MUL;
            end
            ST_MUL: n_state = ST_FIX;
            ST_FIX: begin
                if (i_sts.q_zero) n_state = i_sts.neg ? ST_SIGN : ST_DIGITS;
                else              n_state = ST_MUL;
            end
            ST_SIGN: begin
                if (i_sts.out_free) n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (i_sts.out_free && i_sts.last_digit) n_state = ST_IDLE;
            end
            ST_BAD: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.chk_step = !(i_sts.size_bad || i_sts.chk_bad || i_sts.chk_done);
            end
            ST_MUL:    o_cmd.mul        = 1'b1;
            ST_FIX:    o_cmd.fix        = 1'b1;
            ST_SIGN:   o_cmd.emit_sign  = i_sts.out_free;
            ST_DIGITS: o_cmd.emit_digit = i_sts.out_free;
            ST_BAD:    o_cmd.emit_bad   = i_sts.out_free;
            default:   ;
        endcase
    end

endmodule

FILE: rtl/sirt_checker.sv
// ----------------------------------------------------------------------------
// sirt_checker
// Port-level checks of the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_text_macros.svh"

module sirt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_symbol,
    input logic       o_last_symbol,
    input logic       o_bad_alphabet
);

    `SIRT_ASSERT_IMP(a_bad_lone, o_out_valid && o_bad_alphabet, o_last_symbol && o_symbol == 8'd0)
    `SIRT_ASSERT_IMP(a_idle_only_last, o_out_valid && o_in_ready, o_last_symbol)
    `SIRT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `SIRT_ASSERT_NEXT(a_hold_out, o_out_valid && !i_out_ready, o_out_valid && $stable(o_symbol) && $stable(o_last_symbol) && $stable(o_bad_alphabet))

endmodule

bind signed_integer_to_radix_text sirt_checker u_checker (.*);
